[hdl/spbw_pkg.sv]
// ----------------------------------------------------------------------------
// spbw_pkg
// shared types, constants and register codes of the pulse burst generator
// ----------------------------------------------------------------------------
package spbw_pkg;

  localparam int DEF_POLY_ORDER      = 2;
  localparam int DEF_KEEPALIVE_SHIFT = 0;

  localparam logic [11:0] IDLE_LEVEL = 12'd2047;
  localparam logic [11:0] FULL_LEVEL = 12'd4095;
  localparam logic [11:0] KA_PERIOD  = 12'd2216;
  localparam logic [11:0] KA_SPAN    = 12'd16;
  localparam logic [3:0]  SLOT_WORDS = 4'd10;
  localparam logic [4:0]  MAX_BURST  = 5'd31;

  localparam int CFG_DW = 17;
  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_PULSES_PER_BURST = 3'd0,
    CFG_BURST_COUNT      = 3'd1,
    CFG_LEADING_BURST    = 3'd2,
    CFG_PULSE_AMP        = 3'd3,
    CFG_PULSE_WIDTH      = 3'd4,
    CFG_LEAD_DELAY       = 3'd5,
    CFG_NOTCH_SPACING    = 3'd6,
    CFG_START_FRAC       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0]  pulses_per_burst;
    logic [4:0]  burst_count;
    logic        leading_burst;
    logic [11:0] pulse_amplitude;
    logic [2:0]  pulse_width_words;
    logic [12:0] lead_delay_words;
    logic [15:0] notch_spacing;
    logic [16:0] start_fraction;
  } cfg_t;

  typedef enum logic [5:0] {
    PH_LEAD      = 6'b000001,
    PH_LEADBURST = 6'b000010,
    PH_GAP       = 6'b000100,
    PH_BURST     = 6'b001000,
    PH_TAIL      = 6'b010000,
    PH_END       = 6'b100000
  } phase_t;

  typedef struct packed {
    logic clear;
    logic settle;
    logic advance;
  } pos_cmd_t;

  typedef struct packed {
    logic settled;
    logic ended;
    logic need_amp;
  } pos_stat_t;

  typedef struct packed {
    logic clear;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic div;
  } amp_cmd_t;

endpackage

[hdl/spbw_if.sv]
// ----------------------------------------------------------------------------
// spbw_if
// valid/ready channels of the pulse burst generator
// ----------------------------------------------------------------------------
interface spbw_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface spbw_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] sample_word;
  logic        keepalive_mark;
  logic        last_word;
  logic        past_end;
  modport source (output valid, output sample_word, output keepalive_mark,
                  output last_word, output past_end, input ready);
  modport sink   (input valid, input sample_word, input keepalive_mark,
                  input last_word, input past_end, output ready);
endinterface

[hdl/spbw_ctrl.sv]
// ----------------------------------------------------------------------------
// spbw_ctrl
// sequencer: settle, amplitude evaluation when due, advance, settle, deliver
// ----------------------------------------------------------------------------
module spbw_ctrl
  import spbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_restart,
  input  logic      out_free,
  input  pos_stat_t pos_stat,
  input  logic      div_last,
  output logic      in_ready,
  output pos_cmd_t  pos_cmd,
  output amp_cmd_t  amp_cmd,
  output logic      out_load,
  output logic      out_load_end
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_SET1 = 12'b000000000010,
    S_DEC  = 12'b000000000100,
    S_A1   = 12'b000000001000,
    S_A2   = 12'b000000010000,
    S_A3   = 12'b000000100000,
    S_A4   = 12'b000001000000,
    S_A5   = 12'b000010000000,
    S_DIV  = 12'b000100000000,
    S_ADV  = 12'b001000000000,
    S_SET2 = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    pos_cmd      = '0;
    amp_cmd      = '0;
    out_load     = 1'b0;
    out_load_end = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pos_cmd.clear = in_restart;
          amp_cmd.clear = in_restart;
          state_next    = S_SET1;
        end
      end
      S_SET1: begin
        pos_cmd.settle = 1'b1;
        if (pos_stat.settled) state_next = S_DEC;
      end
      S_DEC: begin
        if (pos_stat.ended) begin
          out_load_end = 1'b1;
          state_next   = S_IDLE;
        end else if (pos_stat.need_amp) begin
          state_next = S_A1;
        end else begin
          state_next = S_ADV;
        end
      end
      S_A1: begin amp_cmd.s1 = 1'b1; state_next = S_A2; end
      S_A2: begin amp_cmd.s2 = 1'b1; state_next = S_A3; end
      S_A3: begin amp_cmd.s3 = 1'b1; state_next = S_A4; end
      S_A4: begin amp_cmd.s4 = 1'b1; state_next = S_A5; end
      S_A5: begin amp_cmd.s5 = 1'b1; state_next = S_DIV; end
      S_DIV: begin
        amp_cmd.div = 1'b1;
        if (div_last) state_next = S_ADV;
      end
      S_ADV: begin
        pos_cmd.advance = 1'b1;
        state_next      = S_SET2;
      end
      S_SET2: begin
        pos_cmd.settle = 1'b1;
        if (pos_stat.settled) state_next = S_FIN;
      end
      S_FIN: begin
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

[hdl/spbw_pos.sv]
// ----------------------------------------------------------------------------
// spbw_pos
// waveform position counters, segment phase and keep-alive marking
// ----------------------------------------------------------------------------
module spbw_pos
  import spbw_pkg::*;
#(
  parameter int KEEPALIVE_SHIFT = DEF_KEEPALIVE_SHIFT
)(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  pos_cmd_t    cmd,
  input  logic [11:0] amp,
  output pos_stat_t   stat,
  output logic [4:0]  amp_burst,
  output logic [4:0]  amp_pulse,
  output logic [11:0] level,
  output logic        mark
);

  localparam int SC_W = (KEEPALIVE_SHIFT > 0) ? $clog2(KEEPALIVE_SHIFT + 1) : 1;

  phase_t      phase, phase_s;
  logic [4:0]  bi, bi_s, pi, pi_s;
  logic [3:0]  wip, wip_s;
  logic [15:0] pad, pad_s;
  logic [5:0]  tot;
  logic [11:0] ka;
  logic [SC_W-1:0] sc;
  logic        ended, ended_s, done;

  logic [8:0]  ten_bw;
  logic [12:0] lead_len;
  logic [15:0] gap_len;
  logic [3:0]  wip_inc;
  logic [11:0] ka_inc;
  logic        in_burst;

  assign ten_bw   = {1'b0, cfg.pulses_per_burst, 3'b000} +
                    {3'b000, cfg.pulses_per_burst, 1'b0};
  assign lead_len = !cfg.leading_burst ? cfg.lead_delay_words :
                    (cfg.lead_delay_words > 13'(ten_bw)) ?
                    cfg.lead_delay_words - 13'(ten_bw) : 13'd0;
  assign gap_len  = (cfg.notch_spacing > 16'(ten_bw)) ?
                    cfg.notch_spacing - 16'(ten_bw) : 16'd0;
  assign in_burst = (phase == PH_BURST) || (phase == PH_LEADBURST);
  assign wip_inc  = wip + 4'd1;
  assign ka_inc   = ka + 12'd1;

  // one pass of the segment settling loop
  always_comb begin
    phase_s = phase; bi_s = bi; pi_s = pi; wip_s = wip; pad_s = pad;
    ended_s = ended; done = 1'b0;
    unique case (phase)
      PH_LEAD: begin
        if (pad < 16'(lead_len)) done = 1'b1;
        else begin
          pad_s = '0; pi_s = '0; wip_s = '0; bi_s = '0;
          phase_s = cfg.leading_burst ? PH_LEADBURST : PH_GAP;
        end
      end
      PH_LEADBURST: begin
        if (pi < cfg.pulses_per_burst) done = 1'b1;
        else begin
          phase_s = PH_GAP; bi_s = '0; pad_s = '0; pi_s = '0; wip_s = '0;
        end
      end
      PH_GAP: begin
        if (bi >= cfg.burst_count) phase_s = PH_TAIL;
        else if (pad < gap_len) done = 1'b1;
        else begin
          phase_s = PH_BURST; pi_s = '0; wip_s = '0;
        end
      end
      PH_BURST: begin
        if (pi < cfg.pulses_per_burst) done = 1'b1;
        else begin
          phase_s = PH_GAP; bi_s = (bi < MAX_BURST) ? bi + 5'd1 : MAX_BURST;
          pad_s = '0; pi_s = '0; wip_s = '0;
        end
      end
      PH_TAIL: begin
        if (tot != 6'd0) done = 1'b1;
        else begin
          phase_s = PH_END; ended_s = 1'b1;
        end
      end
      default: begin
        phase_s = PH_END; ended_s = 1'b1; done = 1'b1;
      end
    endcase
  end

  assign stat.settled  = done;
  assign stat.ended    = ended;
  assign stat.need_amp = in_burst && (wip == 4'd0);
  assign amp_burst     = (phase == PH_BURST) ? bi : 5'd0;
  assign amp_pulse     = pi;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase <= PH_LEAD; bi <= '0; pi <= '0; wip <= '0; pad <= '0;
      tot <= '0; ka <= '0; sc <= '0; ended <= 1'b0;
    end else if (cmd.settle) begin
      phase <= phase_s; bi <= bi_s; pi <= pi_s; wip <= wip_s;
      pad <= pad_s; ended <= ended_s;
    end else if (cmd.advance) begin
      if (in_burst) begin
        if (wip_inc >= SLOT_WORDS) begin
          wip <= '0;
          pi  <= pi + 5'd1;
        end else begin
          wip <= wip_inc;
        end
      end else if (phase != PH_TAIL) begin
        pad <= pad + 16'd1;
      end
      tot <= tot + 6'd1;
      if (sc < SC_W'(KEEPALIVE_SHIFT)) begin
        sc <= sc + SC_W'(1);
      end else begin
        ka <= (ka_inc >= KA_PERIOD) ? 12'd0 : ka_inc;
      end
    end
  end

  // result of the word being advanced past
  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      level <= (in_burst && (wip < {1'b0, cfg.pulse_width_words})) ? amp : IDLE_LEVEL;
      mark  <= !(sc < SC_W'(KEEPALIVE_SHIFT)) && (ka < KA_SPAN) && (ka[1:0] == 2'b00);
    end
  end

endmodule

[hdl/spbw_amp.sv]
// ----------------------------------------------------------------------------
// spbw_amp
// pulse amplitude: shaping curve times burst scale, restoring divide
// ----------------------------------------------------------------------------
module spbw_amp
  import spbw_pkg::*;
#(
  parameter int POLY_ORDER = DEF_POLY_ORDER
)(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  amp_cmd_t    cmd,
  input  logic [4:0]  burst,
  input  logic [4:0]  pulse,
  output logic [11:0] amp,
  output logic        div_last
);

  localparam int ORD_ABS  = (POLY_ORDER < 0) ? -POLY_ORDER : POLY_ORDER;
  localparam int ORD_N    = (ORD_ABS > 3) ? 3 : ORD_ABS;
  localparam bit ORD_NEG  = (POLY_ORDER < 0);
  localparam bit ORD_ZERO = (POLY_ORDER == 0);
  localparam int QW       = 13;
  localparam logic [3:0] QTOP = 4'(QW - 1);

  logic [4:0]  d, kk, bne, bne_v, bb_v, d_v;
  logic [9:0]  d2, k2;
  logic [21:0] sa;
  logic [20:0] sb;
  logic        flat;
  logic [14:0] dn, kn, dn_v, kn_v;
  logic [22:0] snum;
  logic [26:0] p1, p2;
  logic [19:0] denb;
  logic [27:0] num;
  logic [50:0] rem;
  logic [47:0] dv;
  logic [QW-1:0] q, q_next;
  logic [3:0]  cnt;
  logic        fits;

  assign d_v   = cfg.pulses_per_burst - 5'd1;
  assign bne_v = (cfg.burst_count != 5'd0) ? cfg.burst_count : 5'd1;
  assign bb_v  = (burst < bne_v) ? burst : 5'd0;

  always_comb begin
    if (flat) begin
      dn_v = 15'd1;
      kn_v = 15'd0;
    end else if (ORD_N == 3) begin
      dn_v = 15'(d2) * 15'(d);
      kn_v = 15'(k2) * 15'(kk);
    end else if (ORD_N == 2) begin
      dn_v = 15'(d2);
      kn_v = 15'(k2);
    end else begin
      dn_v = 15'(d);
      kn_v = 15'(kk);
    end
  end

  assign fits     = rem >= 51'(dv);
  assign q_next   = {q[QW-2:0], fits};
  assign div_last = (cnt == 4'd0);

  always_ff @(posedge clk) begin
    if (cmd.s1) begin
      d    <= d_v;
      kk   <= (pulse > d_v) ? d_v : pulse;
      d2   <= 10'(d_v) * 10'(d_v);
      k2   <= (pulse > d_v) ? 10'(d_v) * 10'(d_v) : 10'(pulse) * 10'(pulse);
      bne  <= bne_v;
      sa   <= 22'(cfg.start_fraction) * 22'(bne_v - bb_v);
      sb   <= {bb_v, 16'h0000};
      flat <= ORD_ZERO || (cfg.pulses_per_burst <= 5'd1);
    end
    if (cmd.s2) begin
      dn   <= dn_v;
      kn   <= kn_v;
      snum <= 23'(sa) + 23'(sb);
    end
    if (cmd.s3) begin
      p1   <= 27'(cfg.pulse_amplitude) * 27'(dn);
      p2   <= 27'(FULL_LEVEL - cfg.pulse_amplitude) * 27'(kn);
      denb <= 20'(dn) * 20'(bne);
    end
    if (cmd.s4) begin
      // a negative order falls from full scale; a positive order rises from the base, order zero stays at it
      if (ORD_NEG && !ORD_ZERO) num <= {1'b0, dn, 12'h000} - 28'(dn) - 28'(p2);
      else                      num <= 28'(p1) + 28'(p2);
    end
    if (cmd.s5) begin
      rem <= 51'(snum) * 51'(num);
      dv  <= {denb, 28'h0000000};
      cnt <= QTOP;
      q   <= '0;
    end else if (cmd.div) begin
      if (fits) rem <= rem - 51'(dv);
      dv  <= dv >> 1;
      q   <= q_next;
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      amp <= IDLE_LEVEL;
    end else if (cmd.div && div_last) begin
      amp <= q_next[QW-1] ? FULL_LEVEL : q_next[11:0];
    end
  end

endmodule

[hdl/shaped_pulse_burst_waveform_generator.sv]
// ----------------------------------------------------------------------------
// shaped_pulse_burst_waveform_generator
// one dac word of a shaped notch-burst waveform for each input transfer
// ----------------------------------------------------------------------------
// sequence: an input transfer starts the settle passes, one more per segment boundary
//   crossed, then a decision, the advance, a second settle and the result load; the
//   first word of a pulse slot adds the multiply chain and the 13-step divide before
//   the advance; past the end the decision loads the result directly
// flow: one item at a time; the next transfer is taken once idle and the result register is free
// reset: synchronous, control and configuration registers to reset values, position to word zero
module shaped_pulse_burst_waveform_generator
  import spbw_pkg::*;
#(
  parameter int POLY_ORDER      = DEF_POLY_ORDER,
  parameter int KEEPALIVE_SHIFT = DEF_KEEPALIVE_SHIFT
)(
  input  logic              clk,
  input  logic              rst,
  spbw_in_if.sink           in_ch,
  spbw_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t        cfg;
  pos_cmd_t    pos_cmd;
  pos_stat_t   pos_stat;
  amp_cmd_t    amp_cmd;
  logic        div_last, out_load, out_load_end, out_free;
  logic [4:0]  amp_burst, amp_pulse;
  logic [11:0] amp, level;
  logic        mark;

  // configuration registers, each masked to its own width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_burst  <= 5'd8;
      cfg.burst_count       <= 5'd1;
      cfg.leading_burst     <= 1'b0;
      cfg.pulse_amplitude   <= 12'd4095;
      cfg.pulse_width_words <= 3'd2;
      cfg.lead_delay_words  <= 13'd0;
      cfg.notch_spacing     <= 16'd4440;
      cfg.start_fraction    <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PULSES_PER_BURST: cfg.pulses_per_burst  <= cfg_data[4:0];
        CFG_BURST_COUNT:      cfg.burst_count       <= cfg_data[4:0];
        CFG_LEADING_BURST:    cfg.leading_burst     <= cfg_data[0];
        CFG_PULSE_AMP:        cfg.pulse_amplitude   <= cfg_data[11:0];
        CFG_PULSE_WIDTH:      cfg.pulse_width_words <= cfg_data[2:0];
        CFG_LEAD_DELAY:       cfg.lead_delay_words  <= cfg_data[12:0];
        CFG_NOTCH_SPACING:    cfg.notch_spacing     <= cfg_data[15:0];
        CFG_START_FRAC:       cfg.start_fraction    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // the result register may be refilled once its transfer completes
  assign out_free = !out_ch.valid || out_ch.ready;

  spbw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_restart   (in_ch.restart),
    .out_free     (out_free),
    .pos_stat     (pos_stat),
    .div_last     (div_last),
    .in_ready     (in_ch.ready),
    .pos_cmd      (pos_cmd),
    .amp_cmd      (amp_cmd),
    .out_load     (out_load),
    .out_load_end (out_load_end)
  );

  spbw_pos #(
    .KEEPALIVE_SHIFT (KEEPALIVE_SHIFT)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (pos_cmd),
    .amp       (amp),
    .stat      (pos_stat),
    .amp_burst (amp_burst),
    .amp_pulse (amp_pulse),
    .level     (level),
    .mark      (mark)
  );

  spbw_amp #(
    .POLY_ORDER (POLY_ORDER)
  ) u_amp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (amp_cmd),
    .burst    (amp_burst),
    .pulse    (amp_pulse),
    .amp      (amp),
    .div_last (div_last)
  );

  // result register: valid is control, the fields are payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load || out_load_end) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_end) begin
      // past the end: everything zero but the flag
      out_ch.sample_word    <= '0;
      out_ch.keepalive_mark <= 1'b0;
      out_ch.last_word      <= 1'b0;
      out_ch.past_end       <= 1'b1;
    end else if (out_load) begin
      out_ch.sample_word    <= {mark, mark, level};
      out_ch.keepalive_mark <= mark;
      out_ch.last_word      <= pos_stat.ended;
      out_ch.past_end       <= 1'b0;
    end
  end

endmodule

[hdl/spbw_checker.sv]
// ----------------------------------------------------------------------------
// spbw_checker
// port-level checks of the pulse burst generator, bound to the top level
// ----------------------------------------------------------------------------
module spbw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] sample_word,
  input logic        keepalive_mark,
  input logic        last_word,
  input logic        past_end
);

  // a pending result is held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one item in flight: no second transfer right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // an input transfer never overruns an unclaimed result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken with result register full");

  // past the end every other field reads zero
  a_past_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && past_end |-> sample_word == 14'd0 && !keepalive_mark && !last_word)
    else $error("past-end result carries data");

  // the mark flag agrees with the keep-alive bits of the word
  a_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !past_end |-> keepalive_mark == (sample_word[13:12] == 2'b11))
    else $error("keep-alive flag and bits disagree");

endmodule

bind shaped_pulse_burst_waveform_generator spbw_checker u_spbw_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .sample_word    (out_ch.sample_word),
  .keepalive_mark (out_ch.keepalive_mark),
  .last_word      (out_ch.last_word),
  .past_end       (out_ch.past_end)
);
